### rtl/lca_pkg.sv
// Shared types and constants for the line closest-approach unit.
`timescale 1ns / 1ps

package lca_pkg;

    // Width of one multiplier digit; each multiplier stage takes one digit.
    localparam int MUL_DIGIT = 16;

    // Case flags that travel down the pipeline with each word.
    typedef struct packed {
        logic par;
        logic deg;
    } lca_flags_t;

endpackage

### rtl/line_closest_approach_unit.sv
// Top level of the closest-approach unit for two 3D lines.
`timescale 1ns / 1ps

// Closest approach of two lines, each a point and a direction in signed fixed point
// (Q15.16 at the default width; the fraction scale cancels). The unit returns the
// midpoint of the two closest points, their distance, and parallel and degenerate
// flags. It is fully pipelined: a new word is taken every cycle unless the result
// side stalls. Each word passes through 4 + ceil((2W+3)/16) + 2 + ceil((4W+7)/16)
// + (5W+9) + 4 + (W+2) + 1 register stages, with W = COORD_WIDTH (228 at W = 32).
// The divider, one quotient bit per stage, and the square root, one result bit per
// stage, set that depth. A stall on the result side holds every stage at once.
module line_closest_approach_unit
    import lca_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_point_a_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_a_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_a_z,
    input  logic signed [COORD_WIDTH-1:0] s_dir_a_x,
    input  logic signed [COORD_WIDTH-1:0] s_dir_a_y,
    input  logic signed [COORD_WIDTH-1:0] s_dir_a_z,
    input  logic signed [COORD_WIDTH-1:0] s_point_b_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_b_y,
    input  logic signed [COORD_WIDTH-1:0] s_point_b_z,
    input  logic signed [COORD_WIDTH-1:0] s_dir_b_x,
    input  logic signed [COORD_WIDTH-1:0] s_dir_b_y,
    input  logic signed [COORD_WIDTH-1:0] s_dir_b_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_vertex_x,
    output logic signed [COORD_WIDTH-1:0] m_vertex_y,
    output logic signed [COORD_WIDTH-1:0] m_vertex_z,
    output logic [COORD_WIDTH-1:0]        m_separation,
    output logic                          m_parallel_flag,
    output logic                          m_degenerate_flag
);

    localparam int W    = COORD_WIDTH;
    localparam int PRW  = 2 * W + 1;
    localparam int DPW  = 2 * W + 3;
    localparam int PW1  = 2 * DPW;
    localparam int NSW  = PW1 + 1;
    localparam int NUMW = NSW + W;
    localparam int QW   = NUMW + 1;
    localparam int VW   = NUMW + 3;
    localparam int NQ   = W + 2;
    localparam int RW   = 2 * NQ;
    localparam int GW   = 12 * W;
    localparam int SW1  = GW + 2 * DPW;
    localparam int SW2  = 6 * W + 2 + NSW;
    localparam int SW3  = 6 * W + 2;
    localparam int SWQ  = 3 * W + 3;

    // Global advance: the whole pipeline moves when the output slot is free.
    logic m_valid_reg;
    logic en;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Input registers.
    logic signed [W-1:0] pa0_reg [3], da0_reg [3], pb0_reg [3], db0_reg [3];
    logic                v0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa0_reg[0] <= s_point_a_x;
            pa0_reg[1] <= s_point_a_y;
            pa0_reg[2] <= s_point_a_z;
            da0_reg[0] <= s_dir_a_x;
            da0_reg[1] <= s_dir_a_y;
            da0_reg[2] <= s_dir_a_z;
            pb0_reg[0] <= s_point_b_x;
            pb0_reg[1] <= s_point_b_y;
            pb0_reg[2] <= s_point_b_z;
            db0_reg[0] <= s_dir_b_x;
            db0_reg[1] <= s_dir_b_y;
            db0_reg[2] <= s_dir_b_z;
        end
    end

    // Offset between the two base points.
    logic signed [W-1:0] pa1_reg [3], da1_reg [3], pb1_reg [3], db1_reg [3];
    logic signed [W:0]   w1_reg [3];
    logic                v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                w1_reg[i]  <= (W+1)'(pa0_reg[i]) - (W+1)'(pb0_reg[i]);
                pa1_reg[i] <= pa0_reg[i];
                da1_reg[i] <= da0_reg[i];
                pb1_reg[i] <= pb0_reg[i];
                db1_reg[i] <= db0_reg[i];
            end
        end
    end

    // Component products for the five dot products.
    logic signed [PRW-1:0] aa_next [3], ab_next [3], bb_next [3], aw_next [3], bw_next [3];
    logic signed [PRW-1:0] aa2_reg [3], ab2_reg [3], bb2_reg [3], aw2_reg [3], bw2_reg [3];
    logic signed [W-1:0]   pa2_reg [3], da2_reg [3], pb2_reg [3], db2_reg [3];
    logic                  v2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            aa_next[i] = da1_reg[i] * da1_reg[i];
            ab_next[i] = da1_reg[i] * db1_reg[i];
            bb_next[i] = db1_reg[i] * db1_reg[i];
            aw_next[i] = da1_reg[i] * w1_reg[i];
            bw_next[i] = db1_reg[i] * w1_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                aa2_reg[i] <= aa_next[i];
                ab2_reg[i] <= ab_next[i];
                bb2_reg[i] <= bb_next[i];
                aw2_reg[i] <= aw_next[i];
                bw2_reg[i] <= bw_next[i];
                pa2_reg[i] <= pa1_reg[i];
                da2_reg[i] <= da1_reg[i];
                pb2_reg[i] <= pb1_reg[i];
                db2_reg[i] <= db1_reg[i];
            end
        end
    end

    // Dot products a, b, c, d and e.
    logic signed [DPW-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    logic [GW-1:0]         geom3_reg;
    logic                  v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg <= DPW'(aa2_reg[0]) + DPW'(aa2_reg[1]) + DPW'(aa2_reg[2]);
            b3_reg <= DPW'(ab2_reg[0]) + DPW'(ab2_reg[1]) + DPW'(ab2_reg[2]);
            c3_reg <= DPW'(bb2_reg[0]) + DPW'(bb2_reg[1]) + DPW'(bb2_reg[2]);
            d3_reg <= DPW'(aw2_reg[0]) + DPW'(aw2_reg[1]) + DPW'(aw2_reg[2]);
            e3_reg <= DPW'(bw2_reg[0]) + DPW'(bw2_reg[1]) + DPW'(bw2_reg[2]);
            geom3_reg <= {pa2_reg[0], pa2_reg[1], pa2_reg[2],
                          pb2_reg[0], pb2_reg[1], pb2_reg[2],
                          da2_reg[0], da2_reg[1], da2_reg[2],
                          db2_reg[0], db2_reg[1], db2_reg[2]};
        end
    end

    // Products of dot products: ac, bb, be, cd, ae, bd.
    logic signed [DPW-1:0] m1_a [6], m1_b [6];
    logic signed [PW1-1:0] m1_p [6];
    logic [SW1-1:0]        m1_side;
    logic                  m1_valid;

    assign m1_a[0] = a3_reg;  assign m1_b[0] = c3_reg;
    assign m1_a[1] = b3_reg;  assign m1_b[1] = b3_reg;
    assign m1_a[2] = b3_reg;  assign m1_b[2] = e3_reg;
    assign m1_a[3] = c3_reg;  assign m1_b[3] = d3_reg;
    assign m1_a[4] = a3_reg;  assign m1_b[4] = e3_reg;
    assign m1_a[5] = b3_reg;  assign m1_b[5] = d3_reg;

    lca_mul #(
        .NL (6),
        .AW (DPW),
        .BW (DPW),
        .SW (SW1)
    ) u_mul_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_side   ({geom3_reg, c3_reg, e3_reg}),
        .a         (m1_a),
        .b         (m1_b),
        .out_valid (m1_valid),
        .out_side  (m1_side),
        .p         (m1_p)
    );

    // Determinant and the two numerators.
    logic signed [NSW-1:0] det5_reg, ns5_reg, nt5_reg;
    logic signed [DPW-1:0] c5_reg, e5_reg;
    logic [GW-1:0]         geom5_reg;
    logic                  v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= m1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det5_reg  <= NSW'(m1_p[0]) - NSW'(m1_p[1]);
            ns5_reg   <= NSW'(m1_p[2]) - NSW'(m1_p[3]);
            nt5_reg   <= NSW'(m1_p[4]) - NSW'(m1_p[5]);
            geom5_reg <= m1_side[SW1-1:2*DPW];
            c5_reg    <= m1_side[2*DPW-1:DPW];
            e5_reg    <= m1_side[DPW-1:0];
        end
    end

    // Case selection: general, parallel, or zero second direction.
    logic                  par_next, deg_next;
    logic signed [NSW-1:0] div_next, mb_next;
    logic signed [NSW-1:0] div6_reg, mb6_reg, ns6_reg;
    lca_flags_t            flags6_reg;
    logic [GW-1:0]         geom6_reg;
    logic                  v6_reg;

    always_comb begin
        par_next = (det5_reg == '0);
        deg_next = par_next && (c5_reg == '0);
        mb_next  = par_next ? NSW'(e5_reg) : nt5_reg;
        if (!par_next) begin
            div_next = det5_reg;
        end else if (deg_next) begin
            div_next = NSW'(1);
        end else begin
            div_next = NSW'(c5_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div6_reg       <= div_next;
            mb6_reg        <= mb_next;
            ns6_reg        <= ns5_reg;
            flags6_reg.par <= par_next;
            flags6_reg.deg <= deg_next;
            geom6_reg      <= geom5_reg;
        end
    end

    // Direction components scaled by the numerators, one numerator digit per stage.
    logic signed [W-1:0]    m2_a [6];
    logic signed [NSW-1:0]  m2_b [6];
    logic signed [NUMW-1:0] m2_p [6];
    logic [SW2-1:0]         m2_side;
    logic                   m2_valid;
    lca_flags_t             m2_flags;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2_a[i]     = geom6_reg[(5 - i) * W +: W];
            m2_a[3 + i] = geom6_reg[(2 - i) * W +: W];
            m2_b[i]     = ns6_reg;
            m2_b[3 + i] = mb6_reg;
        end
    end

    lca_mul #(
        .NL (6),
        .AW (W),
        .BW (NSW),
        .SW (SW2)
    ) u_mul_num (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_side   ({geom6_reg[GW-1:6*W], flags6_reg, div6_reg}),
        .a         (m2_a),
        .b         (m2_b),
        .out_valid (m2_valid),
        .out_side  (m2_side),
        .p         (m2_p)
    );

    // Offsets along each line: one quotient per component, truncated toward zero.
    logic signed [NUMW-1:0] dv_num [6];
    logic signed [QW-1:0]   dv_quo [6];
    logic [SW3-1:0]         dv_side;
    logic                   dv_valid;

    assign m2_flags = lca_flags_t'(m2_side[NSW+1:NSW]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_num[i]     = m2_flags.par ? '0 : m2_p[i];
            dv_num[3 + i] = m2_flags.deg ? '0 : m2_p[3 + i];
        end
    end

    lca_div #(
        .NL (6),
        .NW (NUMW),
        .DW (NSW),
        .SW (SW3)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m2_valid),
        .in_side   (m2_side[SW2-1:NSW]),
        .num       (dv_num),
        .den       (m2_side[NSW-1:0]),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .quo       (dv_quo)
    );

    // Sum and difference of the closest points.
    logic signed [VW-1:0] sum_g_reg [3], dif_g_reg [3];
    lca_flags_t           flags_g_reg;
    logic                 vg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sum_g_reg[i] <= VW'($signed(dv_side[2 + (5 - i) * W +: W]))
                              + VW'($signed(dv_side[2 + (2 - i) * W +: W]))
                              + VW'(dv_quo[i]) + VW'(dv_quo[3 + i]);
                dif_g_reg[i] <= VW'($signed(dv_side[2 + (5 - i) * W +: W]))
                              - VW'($signed(dv_side[2 + (2 - i) * W +: W]))
                              + VW'(dv_quo[i]) - VW'(dv_quo[3 + i]);
            end
            flags_g_reg <= lca_flags_t'(dv_side[1:0]);
        end
    end

    // Midpoint with truncation toward zero and saturation; distance magnitudes.
    logic signed [VW-1:0] hs_next [3], h_next [3];
    logic [VW-1:0]        ad_next [3];
    logic signed [W-1:0]  vtx_next [3];
    logic                 far_next;
    logic signed [W-1:0]  vtx_h_reg [3];
    logic [W-1:0]         ad_h_reg [3];
    logic                 far_h_reg;
    lca_flags_t           flags_h_reg;
    logic                 vh_reg;

    always_comb begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            hs_next[i] = sum_g_reg[i] + VW'(sum_g_reg[i][VW-1]);
            h_next[i]  = hs_next[i] >>> 1;
            if ((&h_next[i][VW-1:W-1]) || !(|h_next[i][VW-1:W-1])) begin
                vtx_next[i] = h_next[i][W-1:0];
            end else if (h_next[i][VW-1]) begin
                vtx_next[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                vtx_next[i] = {1'b0, {(W-1){1'b1}}};
            end
            ad_next[i] = dif_g_reg[i][VW-1] ? VW'(-dif_g_reg[i]) : VW'(dif_g_reg[i]);
            far_next   = far_next | (|ad_next[i][VW-1:W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                vtx_h_reg[i] <= vtx_next[i];
                ad_h_reg[i]  <= ad_next[i][W-1:0];
            end
            far_h_reg   <= far_next;
            flags_h_reg <= flags_g_reg;
        end
    end

    // Squared distance components.
    logic [2*W-1:0]      sq_i_reg [3];
    logic signed [W-1:0] vtx_i_reg [3];
    logic                far_i_reg;
    lca_flags_t          flags_i_reg;
    logic                vi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vi_reg <= 1'b0;
        end else if (en) begin
            vi_reg <= vh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_i_reg[i]  <= ad_h_reg[i] * ad_h_reg[i];
                vtx_i_reg[i] <= vtx_h_reg[i];
            end
            far_i_reg   <= far_h_reg;
            flags_i_reg <= flags_h_reg;
        end
    end

    // Radicand.
    logic [2*W+1:0]      rad_j_reg;
    logic signed [W-1:0] vtx_j_reg [3];
    logic                far_j_reg;
    lca_flags_t          flags_j_reg;
    logic                vj_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vj_reg <= 1'b0;
        end else if (en) begin
            vj_reg <= vi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_j_reg <= (2*W+2)'(sq_i_reg[0]) + (2*W+2)'(sq_i_reg[1])
                       + (2*W+2)'(sq_i_reg[2]);
            for (int i = 0; i < 3; i++) begin
                vtx_j_reg[i] <= vtx_i_reg[i];
            end
            far_j_reg   <= far_i_reg;
            flags_j_reg <= flags_i_reg;
        end
    end

    // Floored square root, one result bit per stage.
    logic [NQ-1:0]   root_q_reg [NQ];
    logic [NQ+1:0]   rem_q_reg [NQ];
    logic [RW-1:0]   rad_q_reg [NQ];
    logic [SWQ-1:0]  side_q_reg [NQ];
    logic            vq_reg [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_sqrt
        logic [NQ-1:0]  root_in;
        logic [NQ+1:0]  rem_in;
        logic [RW-1:0]  rad_in;
        logic [SWQ-1:0] side_in;
        logic           vld_in;
        logic [NQ+3:0]  rs;
        logic [NQ+3:0]  trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = RW'(rad_j_reg);
            assign side_in = {vtx_j_reg[0], vtx_j_reg[1], vtx_j_reg[2], far_j_reg,
                              flags_j_reg};
            assign vld_in  = vj_reg;
        end else begin : g_next
            assign root_in = root_q_reg[k-1];
            assign rem_in  = rem_q_reg[k-1];
            assign rad_in  = rad_q_reg[k-1];
            assign side_in = side_q_reg[k-1];
            assign vld_in  = vq_reg[k-1];
        end

        assign rs    = {rem_in, rad_in[RW-1-2*k -: 2]};
        assign trial = (NQ+4)'({root_in, 2'b01});
        assign ge    = (rs >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg[k] <= 1'b0;
            end else if (en) begin
                vq_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_q_reg[k] <= {root_in[NQ-2:0], ge};
                rem_q_reg[k]  <= ge ? (NQ+2)'(rs - trial) : rs[NQ+1:0];
                rad_q_reg[k]  <= rad_in;
                side_q_reg[k] <= side_in;
            end
        end
    end

    // Output register.
    logic [NQ-1:0]       root_fin;
    logic [SWQ-1:0]      side_fin;
    lca_flags_t          flags_fin;
    logic [W-1:0]        sep_next;
    logic signed [W-1:0] vx_reg, vy_reg, vz_reg;
    logic [W-1:0]        sep_reg;
    lca_flags_t          flags_out_reg;

    assign root_fin  = root_q_reg[NQ-1];
    assign side_fin  = side_q_reg[NQ-1];
    assign flags_fin = lca_flags_t'(side_fin[1:0]);
    assign sep_next  = (side_fin[2] || (|root_fin[NQ-1:W])) ? '1 : root_fin[W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vq_reg[NQ-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg        <= side_fin[3 + 2*W +: W];
            vy_reg        <= side_fin[3 + W +: W];
            vz_reg        <= side_fin[3 +: W];
            sep_reg       <= sep_next;
            flags_out_reg <= flags_fin;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_vertex_x        = vx_reg;
    assign m_vertex_y        = vy_reg;
    assign m_vertex_z        = vz_reg;
    assign m_separation      = sep_reg;
    assign m_parallel_flag   = flags_out_reg.par;
    assign m_degenerate_flag = flags_out_reg.deg;

    // The shared divisor is never zero once a word reaches the case stage.
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v6_reg |-> (div6_reg != '0))
        else $error("divisor is zero in the case-selection stage");

    // A degenerate result is always a parallel one.
    a_deg_implies_par: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_degenerate_flag) |-> m_parallel_flag)
        else $error("degenerate flag without parallel flag");

    // A stall freezes inner stages, so no word is lost or repeated.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v5_reg) && $stable(vg_reg) && $stable(vj_reg)))
        else $error("pipeline stage moved during a stall");

endmodule

### rtl/lca_mul.sv
// Pipelined multi-lane signed multiplier, one digit of the second operand per stage.
`timescale 1ns / 1ps

module lca_mul
    import lca_pkg::*;
#(
    parameter int NL = 1,
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int SW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [SW-1:0]           in_side,
    input  logic signed [AW-1:0]    a [NL],
    input  logic signed [BW-1:0]    b [NL],
    output logic                    out_valid,
    output logic [SW-1:0]           out_side,
    output logic signed [AW+BW-1:0] p [NL]
);

    localparam int DG  = MUL_DIGIT;
    localparam int ND  = (BW + DG - 1) / DG;
    localparam int BXW = ND * DG;
    localparam int PW  = AW + BW;
    localparam int EW  = AW + BXW + 1;

    logic signed [EW-1:0] acc_reg [ND][NL];
    logic signed [AW-1:0] a_reg [ND][NL];
    logic [BXW-1:0]       b_reg [ND][NL];
    logic [SW-1:0]        side_reg [ND];
    logic                 vld_reg [ND];

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic          vld_in;
        logic [SW-1:0] side_in;

        if (k == 0) begin : g_ctl_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
        end else begin : g_ctl_next
            assign vld_in  = vld_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Valid bit travels with the partial products.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_in;
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic signed [AW-1:0] a_in;
            logic [BXW-1:0]       b_in;
            logic signed [EW-1:0] acc_in;
            logic signed [DG:0]   dig;
            logic signed [AW+DG:0] pp;
            logic signed [EW-1:0] acc_next;

            if (k == 0) begin : g_src_first
                assign a_in   = a[l];
                assign b_in   = BXW'(b[l]);
                assign acc_in = '0;
            end else begin : g_src_next
                assign a_in   = a_reg[k-1][l];
                assign b_in   = b_reg[k-1][l];
                assign acc_in = acc_reg[k-1][l];
            end

            // The top digit carries the sign; lower digits are unsigned.
            if (k == ND - 1) begin : g_dig_top
                assign dig = $signed({b_in[BXW-1], b_in[k*DG +: DG]});
            end else begin : g_dig_low
                assign dig = $signed({1'b0, b_in[k*DG +: DG]});
            end

            assign pp       = a_in * dig;
            assign acc_next = acc_in + (EW'(pp) <<< (k * DG));

            always_ff @(posedge aclk) begin
                if (en) begin
                    acc_reg[k][l] <= acc_next;
                end
            end

            if (k < ND - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        a_reg[k][l] <= a_in;
                        b_reg[k][l] <= b_in;
                    end
                end
            end

            if (k == ND - 1) begin : g_out
                assign p[l] = acc_reg[k][l][PW-1:0];
            end
        end
    end

    assign out_valid = vld_reg[ND-1];
    assign out_side  = side_reg[ND-1];

endmodule

### rtl/lca_div.sv
// Pipelined multi-lane signed divider with a shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module lca_div #(
    parameter int NL = 1,
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SW-1:0]        in_side,
    input  logic signed [NW-1:0] num [NL],
    input  logic signed [DW-1:0] den,
    output logic                 out_valid,
    output logic [SW-1:0]        out_side,
    output logic signed [NW:0]   quo [NL]
);

    // Stage 0 takes magnitudes, stages 1..NW each resolve one bit,
    // stage NW+1 restores the sign.
    logic [NW-1:0]   num_reg [NW+1][NL];
    logic            neg_reg [NW+1][NL];
    logic [DW-1:0]   rem_reg [1:NW][NL];
    logic [DW-1:0]   den_reg [NW];
    logic signed [NW:0] quo_reg [NL];
    logic [SW-1:0]   side_reg [NW+2];
    logic            vld_reg [NW+2];

    // Valid bits and side words along all stages.
    for (genvar s = 0; s < NW + 2; s++) begin : g_ctl
        logic          vld_in;
        logic [SW-1:0] side_in;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_in;
            end
        end
    end

    // Magnitudes and quotient sign.
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den[DW-1] ? DW'(-den) : DW'(den);
            for (int l = 0; l < NL; l++) begin
                num_reg[0][l] <= num[l][NW-1] ? NW'(-num[l]) : NW'(num[l]);
                neg_reg[0][l] <= num[l][NW-1] ^ den[DW-1];
            end
        end
    end

    // Restoring division: shift one numerator bit into the remainder per stage.
    for (genvar k = 1; k <= NW; k++) begin : g_step
        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [DW-1:0] rem_in;
            logic [DW:0]   r;
            logic          ge;
            logic [DW-1:0] rem_next;

            if (k == 1) begin : g_rem_first
                assign rem_in = '0;
            end else begin : g_rem_next
                assign rem_in = rem_reg[k-1][l];
            end

            assign r        = {rem_in, num_reg[k-1][l][NW-1]};
            assign ge       = (r >= {1'b0, den_reg[k-1]});
            assign rem_next = ge ? DW'(r - {1'b0, den_reg[k-1]}) : r[DW-1:0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k][l] <= rem_next;
                    num_reg[k][l] <= {num_reg[k-1][l][NW-2:0], ge};
                    neg_reg[k][l] <= neg_reg[k-1][l];
                end
            end
        end

        if (k < NW) begin : g_den
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    // Sign restore; the quotient truncates toward zero.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                quo_reg[l] <= neg_reg[NW][l] ? -$signed((NW+1)'(num_reg[NW][l]))
                                             : $signed((NW+1)'(num_reg[NW][l]));
            end
        end
    end

    assign quo       = quo_reg;
    assign out_valid = vld_reg[NW+1];
    assign out_side  = side_reg[NW+1];

endmodule
